>>> sv/dpdd_pkg.sv
// ----------------------------------------------------------------------------
// dpdd_pkg: shared definitions for the dual PID differential drive
// Register map, reset values, widths and the control struct between stages.
// ----------------------------------------------------------------------------
package dpdd_pkg;

  // Fixed field widths
  localparam int TARGET_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int SUM_W     = 32;
  localparam int FRAC_BITS = 16;  // Q8.8 times Q8.8 gives Q16.16
  localparam int DUTY_W    = 8;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_TARGET = 3'd0,
    REG_TURN_TARGET  = 3'd1,
    REG_SPEED_P_GAIN = 3'd2,
    REG_SPEED_I_GAIN = 3'd3,
    REG_SPEED_D_GAIN = 3'd4,
    REG_TURN_P_GAIN  = 3'd5,
    REG_TURN_I_GAIN  = 3'd6,
    REG_TURN_D_GAIN  = 3'd7
  } cfg_reg_e;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] RST_SPEED_TARGET = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_TURN_TARGET  = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_SPEED_P_GAIN = 16'd128;   // 0.5
  localparam logic [CFG_DATA_W-1:0] RST_SPEED_I_GAIN = 16'd45;    // about 0.175
  localparam logic [CFG_DATA_W-1:0] RST_SPEED_D_GAIN = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_TURN_P_GAIN  = 16'd7680;  // 30
  localparam logic [CFG_DATA_W-1:0] RST_TURN_I_GAIN  = 16'd4480;  // 17.5
  localparam logic [CFG_DATA_W-1:0] RST_TURN_D_GAIN  = 16'd0;

  typedef logic [GAIN_W-1:0] gain_t;

  typedef struct packed {
    gain_t kp;
    gain_t ki;
    gain_t kd;
  } pid_gains_t;

  // Stage load strobes handed from the top level to each loop
  typedef struct packed {
    logic accept;  // item taken: load stage 1 and update loop state
    logic en2;     // load product stage
    logic en3;     // load command stage
  } pipe_ctrl_t;

  // Error width: target minus sample, exact
  function automatic int err_width(int sb);
    return ((sb > TARGET_W) ? sb : TARGET_W) + 1;
  endfunction

  // Loop command width: widest product plus growth of a three-term sum
  function automatic int cmd_width(int sb);
    int pd;
    int pi;
    pd = err_width(sb) + GAIN_W + 2;
    pi = SUM_W + GAIN_W + 1;
    return ((pd > pi) ? pd : pi) + 2;
  endfunction

endpackage

>>> sv/dpdd_pid.sv
// ----------------------------------------------------------------------------
// dpdd_pid: one pipelined PID loop
// Stage 1 forms the error, saturating integral and delta; stage 2 the three
// gain products; stage 3 the loop command in Q16.16.
// ----------------------------------------------------------------------------
module dpdd_pid #(
  parameter int SAMPLE_BITS = 16,
  localparam int CW = dpdd_pkg::cmd_width(SAMPLE_BITS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dpdd_pkg::pipe_ctrl_t          ctrl_i,
  input  logic [dpdd_pkg::TARGET_W-1:0] target_i,
  input  logic [SAMPLE_BITS-1:0]        measured_i,
  input  dpdd_pkg::pid_gains_t          gains_i,
  output logic signed [CW-1:0]          cmd_o
);
  import dpdd_pkg::*;

  localparam int EW = err_width(SAMPLE_BITS);
  localparam int PPW = EW + GAIN_W + 1;     // kp * error
  localparam int PIW = SUM_W + GAIN_W + 1;  // ki * sum
  localparam int PDW = EW + GAIN_W + 2;     // kd * delta

  logic signed [SUM_W-1:0] sum_q;
  logic signed [EW-1:0]    last_q;

  logic signed [EW-1:0]    err_d;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [EW:0]      delta_d;

  logic signed [EW-1:0]    err_q;
  logic signed [SUM_W-1:0] sumv_q;
  logic signed [EW:0]      delta_q;

  logic signed [PPW-1:0]   p_q;
  logic signed [PIW-1:0]   i_q;
  logic signed [PDW-1:0]   d_q;
  logic signed [CW-1:0]    cmd_q;

  // Error, saturating integral and delta
  always_comb begin
    err_d = $signed({{(EW-TARGET_W){target_i[TARGET_W-1]}}, target_i})
          - $signed({{(EW-SAMPLE_BITS){measured_i[SAMPLE_BITS-1]}}, measured_i});
    sum_ext = $signed({sum_q[SUM_W-1], sum_q})
            + $signed({{(SUM_W+1-EW){err_d[EW-1]}}, err_d});
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_d = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_d = sum_ext[SUM_W-1:0];
    end
    delta_d = $signed({err_d[EW-1], err_d}) - $signed({last_q[EW-1], last_q});
  end

  // Loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
    end else if (ctrl_i.accept) begin
      sum_q  <= sum_d;
      last_q <= err_d;
    end
  end

  // Stage 1
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      err_q   <= err_d;
      sumv_q  <= sum_d;
      delta_q <= delta_d;
    end
  end

  // Stage 2: gain products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      p_q <= $signed({1'b0, gains_i.kp}) * err_q;
      i_q <= $signed({1'b0, gains_i.ki}) * sumv_q;
      d_q <= $signed({1'b0, gains_i.kd}) * delta_q;
    end
  end

  // Stage 3: loop command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      cmd_q <= CW'(p_q) + CW'(i_q) + CW'(d_q);
    end
  end

  assign cmd_o = cmd_q;

endmodule

>>> sv/dual_pid_differential_drive_top.sv
// ----------------------------------------------------------------------------
// dual_pid_differential_drive_top: two PID loops mixed into wheel commands
// Each accepted item is registered in stage 1, products, command, wheel mix and output.
// Throughput: one item per cycle; five register stages with per-stage flow
// control, so a waiting result only stalls input once the pipe is full.
// Reset: clears integrators, previous errors and all valid flags, and loads
// the register defaults. Results: left/right duty with reverse bits.
// ----------------------------------------------------------------------------
module dual_pid_differential_drive_top #(
  parameter int DUTY_MAX    = 255,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [dpdd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpdd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // measured_speed, measured_turn
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata   // left_duty[7:0], left_reverse,
                                                         // right_duty[7:0], right_reverse
);
  import dpdd_pkg::*;

  localparam int CW = cmd_width(SAMPLE_BITS);
  localparam int WW = CW + 1;
  localparam logic signed [WW-1:0] LIM     = WW'(DUTY_MAX) << FRAC_BITS;
  localparam logic signed [WW-1:0] ONE     = WW'(1) << FRAC_BITS;
  localparam logic signed [WW-1:0] NEG_ONE = -ONE;

  // Configuration registers
  logic [CFG_DATA_W-1:0] speed_target_q, turn_target_q;
  logic [CFG_DATA_W-1:0] speed_p_q, speed_i_q, speed_d_q;
  logic [CFG_DATA_W-1:0] turn_p_q, turn_i_q, turn_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_target_q <= RST_SPEED_TARGET;
      turn_target_q  <= RST_TURN_TARGET;
      speed_p_q      <= RST_SPEED_P_GAIN;
      speed_i_q      <= RST_SPEED_I_GAIN;
      speed_d_q      <= RST_SPEED_D_GAIN;
      turn_p_q       <= RST_TURN_P_GAIN;
      turn_i_q       <= RST_TURN_I_GAIN;
      turn_d_q       <= RST_TURN_D_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPEED_TARGET: speed_target_q <= cfg_wdata_i;
        REG_TURN_TARGET:  turn_target_q  <= cfg_wdata_i;
        REG_SPEED_P_GAIN: speed_p_q      <= cfg_wdata_i;
        REG_SPEED_I_GAIN: speed_i_q      <= cfg_wdata_i;
        REG_SPEED_D_GAIN: speed_d_q      <= cfg_wdata_i;
        REG_TURN_P_GAIN:  turn_p_q       <= cfg_wdata_i;
        REG_TURN_I_GAIN:  turn_i_q       <= cfg_wdata_i;
        REG_TURN_D_GAIN:  turn_d_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or moving on
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic en1, en2, en3, en4, en_out;
  logic accept;
  pipe_ctrl_t ctrl;

  assign en_out = !ov_q || m_axis_tready;
  assign en4    = !v4_q || en_out;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept = s_axis_tvalid && en1;

  assign ctrl.accept = accept;
  assign ctrl.en2    = en2;
  assign ctrl.en3    = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= s_axis_tvalid;
      if (en2)    v2_q <= v1_q;
      if (en3)    v3_q <= v2_q;
      if (en4)    v4_q <= v3_q;
      if (en_out) ov_q <= v4_q;
    end
  end

  // The two loops
  pid_gains_t speed_gains, turn_gains;
  logic signed [CW-1:0] speed_cmd, turn_cmd;

  assign speed_gains = '{kp: speed_p_q, ki: speed_i_q, kd: speed_d_q};
  assign turn_gains  = '{kp: turn_p_q,  ki: turn_i_q,  kd: turn_d_q};

  dpdd_pid #(.SAMPLE_BITS(SAMPLE_BITS)) u_speed_pid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .target_i   (speed_target_q),
    .measured_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .gains_i    (speed_gains),
    .cmd_o      (speed_cmd)
  );

  dpdd_pid #(.SAMPLE_BITS(SAMPLE_BITS)) u_turn_pid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .target_i   (turn_target_q),
    .measured_i (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .gains_i    (turn_gains),
    .cmd_o      (turn_cmd)
  );

  // Stage 4: wheel mix
  logic signed [WW-1:0] q1_q, q2_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      q1_q <= WW'(speed_cmd) + WW'(turn_cmd);
      q2_q <= WW'(speed_cmd) - WW'(turn_cmd);
    end
  end

  // Clamp, truncate toward zero, split into magnitude and direction
  logic [WW-1:0] abs1, abs2, mag1, mag2;
  logic [DUTY_W-1:0] left_duty_d, right_duty_d;
  logic left_rev_d, right_rev_d;

  always_comb begin
    abs1 = q1_q[WW-1] ? WW'(-q1_q) : WW'(q1_q);
    abs2 = q2_q[WW-1] ? WW'(-q2_q) : WW'(q2_q);
    mag1 = (abs1 > LIM) ? LIM : abs1;
    mag2 = (abs2 > LIM) ? LIM : abs2;
    left_duty_d  = mag1[FRAC_BITS +: DUTY_W];
    right_duty_d = mag2[FRAC_BITS +: DUTY_W];
    // first wheel command truncates to zero or below
    left_rev_d  = (q1_q < ONE);
    // second wheel is negated: reverse when its source truncates to zero or above
    right_rev_d = (q2_q > NEG_ONE);
  end

  // Output register
  logic [DUTY_W-1:0] left_duty_q, right_duty_q;
  logic left_rev_q, right_rev_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      left_duty_q  <= left_duty_d;
      right_duty_q <= right_duty_d;
      left_rev_q   <= left_rev_d;
      right_rev_q  <= right_rev_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, right_rev_q, right_duty_q, left_rev_q, left_duty_q};

endmodule

>>> tb/sv/drive_command_checker.sv
// ----------------------------------------------------------------------------
// drive_command_checker: wheel command predictor and result comparator
// Watches the register write port and both streams of the dual PID drive,
// keeps its own copy of the targets, gains, integrators and previous errors,
// and checks every result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module drive_command_checker #(
  parameter int DUTY_MAX = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Register write port, as seen by the block
  input  logic                            cfg_we_i,
  input  logic [dpdd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpdd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [31:0]                     in_data_i,   // measured_speed, measured_turn
  // Output stream
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [23:0]                     out_data_i,  // left_duty[7:0], left_reverse,
                                                       // right_duty[7:0], right_reverse
  output int                              mismatch_count_o,
  output int                              pending_o
);
  import dpdd_pkg::*;

  localparam longint SUM_MAX        = 2147483647;
  localparam longint SUM_MIN        = -SUM_MAX - 1;
  localparam longint DUTY_LIMIT_Q16 = longint'(DUTY_MAX) * 65536;

  // One result item, lowest field last
  typedef struct packed {
    logic [5:0]        pad;
    logic              right_reverse;
    logic [DUTY_W-1:0] right_duty;
    logic              left_reverse;
    logic [DUTY_W-1:0] left_duty;
  } wheel_cmd_t;

  // Shadow configuration and loop state
  logic signed [TARGET_W-1:0] speed_target;
  logic signed [TARGET_W-1:0] turn_target;
  pid_gains_t                 speed_gains;
  pid_gains_t                 turn_gains;
  logic signed [SUM_W-1:0]    speed_sum;
  logic signed [SUM_W-1:0]    turn_sum;
  logic signed [16:0]         speed_last;
  logic signed [16:0]         turn_last;

  wheel_cmd_t expected_commands[$];
  wheel_cmd_t oldest;
  wheel_cmd_t observed;
  int         mismatches;

  function automatic longint saturate_sum(longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // Q8.8 gain times Q8.8 value gives Q16.16
  function automatic longint loop_command(longint err, longint sum, longint delta,
                                          pid_gains_t g);
    return longint'(g.kp) * err + longint'(g.ki) * sum + longint'(g.kd) * delta;
  endfunction

  // Clamp to +-DUTY_MAX, then drop the fraction toward zero
  function automatic longint wheel_value(longint q16);
    longint v;
    v = q16;
    if (v > DUTY_LIMIT_Q16) v = DUTY_LIMIT_Q16;
    if (v < -DUTY_LIMIT_Q16) v = -DUTY_LIMIT_Q16;
    return v / 65536;
  endfunction

  function automatic wheel_cmd_t pack_command(longint first, longint second);
    wheel_cmd_t c;
    c               = '0;
    c.left_duty     = DUTY_W'(first < 0 ? -first : first);
    c.left_reverse  = (first <= 0);
    c.right_duty    = DUTY_W'(second < 0 ? -second : second);
    c.right_reverse = (second <= 0);
    return c;
  endfunction

  // Advance both loops by one tick and queue the wheel commands
  task automatic predict_wheel_commands(logic [31:0] sample);
    longint es;
    longint et;
    longint ds;
    longint dt;
    longint cs;
    longint ct;
    es = longint'(speed_target) - longint'($signed(sample[15:0]));
    et = longint'(turn_target) - longint'($signed(sample[31:16]));
    speed_sum  = SUM_W'(saturate_sum(longint'(speed_sum) + es));
    turn_sum   = SUM_W'(saturate_sum(longint'(turn_sum) + et));
    ds         = es - longint'(speed_last);
    dt         = et - longint'(turn_last);
    speed_last = es[16:0];
    turn_last  = et[16:0];
    cs = loop_command(es, longint'(speed_sum), ds, speed_gains);
    ct = loop_command(et, longint'(turn_sum), dt, turn_gains);
    expected_commands.push_back(pack_command(wheel_value(cs + ct), -wheel_value(cs - ct)));
  endtask

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
    end
  endtask

  // Register writes, result compare, then prediction of the accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_target   = RST_SPEED_TARGET;
      turn_target    = RST_TURN_TARGET;
      speed_gains.kp = RST_SPEED_P_GAIN;
      speed_gains.ki = RST_SPEED_I_GAIN;
      speed_gains.kd = RST_SPEED_D_GAIN;
      turn_gains.kp  = RST_TURN_P_GAIN;
      turn_gains.ki  = RST_TURN_I_GAIN;
      turn_gains.kd  = RST_TURN_D_GAIN;
      speed_sum      = '0;
      turn_sum       = '0;
      speed_last     = '0;
      turn_last      = '0;
      mismatches     = 0;
      expected_commands.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SPEED_TARGET: speed_target   = cfg_wdata_i;
          REG_TURN_TARGET:  turn_target    = cfg_wdata_i;
          REG_SPEED_P_GAIN: speed_gains.kp = cfg_wdata_i;
          REG_SPEED_I_GAIN: speed_gains.ki = cfg_wdata_i;
          REG_SPEED_D_GAIN: speed_gains.kd = cfg_wdata_i;
          REG_TURN_P_GAIN:  turn_gains.kp  = cfg_wdata_i;
          REG_TURN_I_GAIN:  turn_gains.ki  = cfg_wdata_i;
          REG_TURN_D_GAIN:  turn_gains.kd  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_commands.size() == 0) begin
          mismatches++;
          $error("result item with none expected: tdata %h", out_data_i);
        end else begin
          oldest   = expected_commands.pop_front();
          observed = wheel_cmd_t'(out_data_i);
          check_field("left_duty", oldest.left_duty, observed.left_duty);
          check_field("left_reverse", oldest.left_reverse, observed.left_reverse);
          check_field("right_duty", oldest.right_duty, observed.right_duty);
          check_field("right_reverse", oldest.right_reverse, observed.right_reverse);
          check_field("tdata padding", oldest.pad, observed.pad);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_wheel_commands(in_data_i);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_commands.size();
  end

endmodule

>>> tb/sv/dual_pid_differential_drive_top_test.sv
// ----------------------------------------------------------------------------
// dual_pid_differential_drive_top_test: stimulus and verdict for the drive
// Directed ticks at the field extremes, a zero command, truncation toward
// zero and clamping, then random ticks under changing gains and targets with
// random idling on both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module dual_pid_differential_drive_top_test;
  import dpdd_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_COUNT   = 15;
  localparam int PHASE_ITEMS   = 129;
  localparam int DRAIN_CYCLES  = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // measured_speed, measured_turn
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;   // left_duty[7:0], left_reverse,
                                         // right_duty[7:0], right_reverse

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_output   = 1'b0;
  logic        hold_served   = 1'b0;
  logic [15:0] cur_speed_target;
  logic [15:0] cur_turn_target;
  int          mismatch_count;
  int          pending;
  int          cycle_count   = 0;

  always #1 clk_i = ~clk_i;

  dual_pid_differential_drive_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drive_command_checker command_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output side: random back-pressure, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output && !hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_served = 1'b1;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stop offering items and wait for every outstanding result
  task automatic wait_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_config(logic [15:0] st, logic [15:0] tt,
                             logic [15:0] skp, logic [15:0] ski, logic [15:0] skd,
                             logic [15:0] tkp, logic [15:0] tki, logic [15:0] tkd);
    wait_results();
    write_reg(REG_SPEED_TARGET, st);
    write_reg(REG_TURN_TARGET, tt);
    write_reg(REG_SPEED_P_GAIN, skp);
    write_reg(REG_SPEED_I_GAIN, ski);
    write_reg(REG_SPEED_D_GAIN, skd);
    write_reg(REG_TURN_P_GAIN, tkp);
    write_reg(REG_TURN_I_GAIN, tki);
    write_reg(REG_TURN_D_GAIN, tkd);
    cur_speed_target = st;
    cur_turn_target  = tt;
  endtask

  task automatic send_sample(logic [15:0] speed, logic [15:0] turn);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {turn, speed};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9)) inside
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      [2:4]:   return 16'($urandom_range(511));
      [5:7]:   return 16'($urandom_range(4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a measurement close to the setpoint, sometimes anything at all
  function automatic logic [15:0] random_measure(logic [15:0] target);
    logic [15:0] noise;
    int          roll;
    roll  = $urandom_range(99);
    noise = 16'($urandom);
    if (roll < 5) return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
    if (roll < 30) return noise;
    return target - 16'($signed(noise) >>> $urandom_range(15));
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SPEED_TARGET;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cur_speed_target = RST_SPEED_TARGET;
    cur_turn_target  = RST_TURN_TARGET;
    send_idle_pct = 19;
    recv_idle_pct = 72;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset gains: zero command, then measurement extremes
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h0000);

    // Extreme targets and gains, largest error and derivative swings
    load_config(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF,
                16'h0000, 16'hFFFF, 16'h0001);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h0000);

    // All gains zero: zero command with nonzero errors
    load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h1234, 16'h8000);

    // Unity proportional gain: exact duties and truncation toward zero
    load_config(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
                16'h0100, 16'h0000, 16'h0000);
    send_sample(16'hF600, 16'h0000);
    send_sample(16'h0000, 16'hF600);
    send_sample(16'h0180, 16'h0000);
    send_sample(16'hFE80, 16'h0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h0000, 16'h0000);

    // Random ticks: sender light, receiver heavy; then swapped; then none
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      load_config(pick_target(), pick_target(), pick_gain(), pick_gain(), pick_gain(),
                  pick_gain(), pick_gain(), pick_gain());
      if (ph < PHASE_COUNT / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 72;
      end else if (ph < 2 * PHASE_COUNT / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_output   = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        send_sample(random_measure(cur_speed_target), random_measure(cur_turn_target));
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
